// ===== design/mri_pkg.sv =====
// ----------------------------------------------------------------------------
// mri_pkg: shared definitions for the motor ramp with interlock
// Command, status and register index codes, field types and reset values.
// ----------------------------------------------------------------------------
package mri_pkg;

  // Field widths fixed by the item format
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int SPEED_W  = 11;
  localparam int PCT_W    = 7;
  localparam int ACCEL_W  = 4;
  localparam int TICKS_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int TIME_WIDTH_DEF = 32;

  typedef logic [CMD_W-1:0]          cmd_t;
  typedef logic [STATUS_W-1:0]       status_t;
  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic [PCT_W-1:0]          pct_t;
  typedef logic [ACCEL_W-1:0]        accel_t;
  typedef logic [TICKS_W-1:0]        ticks_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

  // Request commands
  localparam cmd_t CMD_TICK    = 2'd0;
  localparam cmd_t CMD_FORWARD = 2'd1;
  localparam cmd_t CMD_REVERSE = 2'd2;
  localparam cmd_t CMD_STOP    = 2'd3;

  // Result status
  localparam status_t STATUS_TICK   = 2'd0;
  localparam status_t STATUS_ACCEPT = 2'd1;
  localparam status_t STATUS_LOCKED = 2'd2;

  // Register indexes
  localparam cfg_idx_t CFG_FORWARD_SPEED  = 3'd0;
  localparam cfg_idx_t CFG_REVERSE_SPEED  = 3'd1;
  localparam cfg_idx_t CFG_ACCEL_LEVEL    = 3'd2;
  localparam cfg_idx_t CFG_DEBOUNCE       = 3'd3;
  localparam cfg_idx_t CFG_STARTUP_HOLD   = 3'd4;
  localparam cfg_idx_t CFG_REMOTE_TIMEOUT = 3'd5;
  localparam cfg_idx_t CFG_REMOTE_MAX     = 3'd6;

  // Limits and scaling
  localparam pct_t   SPEED_PCT_MAX = 7'd100;
  localparam accel_t ACCEL_MIN     = 4'd1;
  localparam accel_t ACCEL_MAX     = 4'd10;
  localparam int     RAMP_MULT     = 3;   // tenths of a percent per level
  localparam int     TARGET_SCALE  = 10;  // percent to tenths

  // Register reset values
  localparam pct_t   RST_FORWARD_SPEED  = 7'd70;
  localparam pct_t   RST_REVERSE_SPEED  = 7'd70;
  localparam accel_t RST_ACCEL_LEVEL    = 4'd3;
  localparam ticks_t RST_DEBOUNCE       = 16'd5;
  localparam ticks_t RST_STARTUP_HOLD   = 16'd150;
  localparam ticks_t RST_REMOTE_TIMEOUT = 16'd25;
  localparam ticks_t RST_REMOTE_MAX     = 16'd3000;

endpackage

// ===== design/mri_if.sv =====
// ----------------------------------------------------------------------------
// mri_if: request and result channels of the motor ramp with interlock
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mri_in_if import mri_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t command;
  logic raw_forward;
  logic raw_reverse;

  modport source (output valid, output command, output raw_forward,
                  output raw_reverse, input ready);
  modport sink   (input valid, input command, input raw_forward,
                  input raw_reverse, output ready);
endinterface

interface mri_out_if import mri_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  speed_t  motor_speed;
  logic    drive_ready;
  logic    active_forward;
  logic    active_reverse;

  modport source (output valid, output status, output motor_speed,
                  output drive_ready, output active_forward,
                  output active_reverse, input ready);
  modport sink   (input valid, input status, input motor_speed,
                  input drive_ready, input active_forward,
                  input active_reverse, output ready);
endinterface

// ===== design/motor_ramp_with_interlock.sv =====
// ----------------------------------------------------------------------------
// motor_ramp_with_interlock: speed ramp with startup interlock and remote drive
// Debounces two buttons, enforces a startup release hold, times out remote
// drive and ramps a signed speed toward the selected target.
// ----------------------------------------------------------------------------
// Each request is a tick (carrying raw forward/reverse button levels) or a
// remote forward, reverse or stop command, and each gives exactly one result.
// The block takes a new request every clock unless stalled: a request is
// captured in an input register, and then one pass of compares and a single
// ramp add updates the state and loads the result register. A result is
// valid once its request has passed the input register and the result
// register, and can then be taken; sustained throughput is one request per
// cycle while the result side keeps taking results. When the
// result register is full and not taken, both stages hold and in_if.ready
// stays high only while the input register is empty. Speed is in tenths of
// a percent (-1000..1000) and reads zero until the interlock releases, which
// needs both debounced buttons released for startup_hold_ticks ticks; until
// then remote commands answer locked and change nothing. Registers may be
// written only while no request is in flight; speed values above 100 are
// clamped to 100 and the acceleration level to 1..10 when written. Tick
// arithmetic wraps at TIME_WIDTH bits.
// ----------------------------------------------------------------------------
module motor_ramp_with_interlock
  import mri_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mri_in_if.sink    in_if,
  mri_out_if.source out_if,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_index,
  input  cfg_data_t cfg_data
);

  typedef logic [TIME_WIDTH-1:0] tick_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  pct_t   fwd_speed_r, rev_speed_r;
  accel_t accel_r;
  ticks_t debounce_r, hold_r, timeout_r, max_drive_r;

  pct_t   pct_wr;
  accel_t accel_wr;

  // Clamp written values into range
  always_comb begin
    pct_wr   = cfg_data[PCT_W-1:0];
    if (pct_wr > SPEED_PCT_MAX) pct_wr = SPEED_PCT_MAX;
    accel_wr = cfg_data[ACCEL_W-1:0];
    if (accel_wr < ACCEL_MIN) accel_wr = ACCEL_MIN;
    else if (accel_wr > ACCEL_MAX) accel_wr = ACCEL_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_speed_r <= RST_FORWARD_SPEED;
      rev_speed_r <= RST_REVERSE_SPEED;
      accel_r     <= RST_ACCEL_LEVEL;
      debounce_r  <= RST_DEBOUNCE;
      hold_r      <= RST_STARTUP_HOLD;
      timeout_r   <= RST_REMOTE_TIMEOUT;
      max_drive_r <= RST_REMOTE_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FORWARD_SPEED:  fwd_speed_r <= pct_wr;
        CFG_REVERSE_SPEED:  rev_speed_r <= pct_wr;
        CFG_ACCEL_LEVEL:    accel_r     <= accel_wr;
        CFG_DEBOUNCE:       debounce_r  <= cfg_data[TICKS_W-1:0];
        CFG_STARTUP_HOLD:   hold_r      <= cfg_data[TICKS_W-1:0];
        CFG_REMOTE_TIMEOUT: timeout_r   <= cfg_data[TICKS_W-1:0];
        CFG_REMOTE_MAX:     max_drive_r <= cfg_data[TICKS_W-1:0];
        default: ; // indexes beyond the list are ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register and stall control
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  cmd_t s1_cmd_r;
  logic s1_raw_fwd_r, s1_raw_rev_r;
  logic out_valid_r;
  logic advance;     // result register free to take the held request
  logic in_accept;
  logic work;        // request evaluated this cycle

  assign advance     = !out_valid_r || out_if.ready;
  assign in_if.ready = advance || !s1_valid_r;
  assign in_accept   = in_if.valid && in_if.ready;
  assign work        = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Payload carries no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r     <= in_if.command;
      s1_raw_fwd_r <= in_if.raw_forward;
      s1_raw_rev_r <= in_if.raw_reverse;
    end
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  tick_t  tick_r, tick_nxt;
  logic   fwd_seen_r, fwd_seen_nxt, fwd_stable_r, fwd_stable_nxt;
  tick_t  fwd_chg_r, fwd_chg_nxt;
  logic   rev_seen_r, rev_seen_nxt, rev_stable_r, rev_stable_nxt;
  tick_t  rev_chg_r, rev_chg_nxt;
  logic   ready_flag_r, ready_flag_nxt;
  logic   rel_valid_r, rel_valid_nxt;
  tick_t  rel_start_r, rel_start_nxt;
  logic   rem_fwd_r, rem_fwd_nxt, rem_rev_r, rem_rev_nxt;
  tick_t  last_cmd_r, last_cmd_nxt;
  tick_t  drive_start_r, drive_start_nxt;
  speed_t speed_r, speed_nxt;
  status_t status_nxt;

  tick_t now;
  logic  act_fwd, act_rev, was_idle;
  logic  [SPEED_W-1:0] fwd_tgt_mag, rev_tgt_mag;
  logic  signed [SPEED_W:0] target, rate, step_up, step_dn, cur_w;

  always_comb begin
    tick_nxt        = tick_r;
    fwd_seen_nxt    = fwd_seen_r;
    fwd_stable_nxt  = fwd_stable_r;
    fwd_chg_nxt     = fwd_chg_r;
    rev_seen_nxt    = rev_seen_r;
    rev_stable_nxt  = rev_stable_r;
    rev_chg_nxt     = rev_chg_r;
    ready_flag_nxt  = ready_flag_r;
    rel_valid_nxt   = rel_valid_r;
    rel_start_nxt   = rel_start_r;
    rem_fwd_nxt     = rem_fwd_r;
    rem_rev_nxt     = rem_rev_r;
    last_cmd_nxt    = last_cmd_r;
    drive_start_nxt = drive_start_r;
    speed_nxt       = speed_r;
    status_nxt      = STATUS_TICK;
    now             = tick_r + tick_t'(1);
    was_idle        = !rem_fwd_r && !rem_rev_r;
    act_fwd         = 1'b0;
    act_rev         = 1'b0;

    fwd_tgt_mag = SPEED_W'(fwd_speed_r) * SPEED_W'(TARGET_SCALE);
    rev_tgt_mag = SPEED_W'(rev_speed_r) * SPEED_W'(TARGET_SCALE);
    target      = '0;
    rate        = '0;
    cur_w       = (SPEED_W+1)'(speed_r);
    step_up     = '0;
    step_dn     = '0;

    if (s1_cmd_r != CMD_TICK) begin
      // Remote command: answer locked until the interlock releases
      if (!ready_flag_r) begin
        status_nxt = STATUS_LOCKED;
      end else begin
        unique case (s1_cmd_r)
          CMD_FORWARD: begin
            rem_fwd_nxt = 1'b1;
            rem_rev_nxt = 1'b0;
          end
          CMD_REVERSE: begin
            rem_fwd_nxt = 1'b0;
            rem_rev_nxt = 1'b1;
          end
          default: begin
            rem_fwd_nxt     = 1'b0;
            rem_rev_nxt     = 1'b0;
            drive_start_nxt = '0;
          end
        endcase
        if ((rem_fwd_nxt || rem_rev_nxt) && was_idle) drive_start_nxt = tick_r;
        last_cmd_nxt = tick_r;
        status_nxt   = STATUS_ACCEPT;
      end
    end else begin
      tick_nxt = now;

      // Debounce: restart the hold time on every raw change
      if (s1_raw_fwd_r != fwd_seen_r) begin
        fwd_seen_nxt = s1_raw_fwd_r;
        fwd_chg_nxt  = now;
      end
      if ((now - fwd_chg_nxt) >= TIME_WIDTH'(debounce_r)) fwd_stable_nxt = fwd_seen_nxt;
      if (s1_raw_rev_r != rev_seen_r) begin
        rev_seen_nxt = s1_raw_rev_r;
        rev_chg_nxt  = now;
      end
      if ((now - rev_chg_nxt) >= TIME_WIDTH'(debounce_r)) rev_stable_nxt = rev_seen_nxt;

      if (!ready_flag_r) begin
        // Interlock: both buttons released for the hold time
        if (!fwd_stable_nxt && !rev_stable_nxt) begin
          if (!rel_valid_r) begin
            rel_valid_nxt = 1'b1;
            rel_start_nxt = now;
          end
          if ((now - rel_start_nxt) >= TIME_WIDTH'(hold_r)) ready_flag_nxt = 1'b1;
        end else begin
          rel_valid_nxt = 1'b0;
        end
      end else begin
        // Drop remote drive on command timeout or maximum drive time
        if (!was_idle &&
            (((now - last_cmd_r) > TIME_WIDTH'(timeout_r)) ||
             ((now - drive_start_r) > TIME_WIDTH'(max_drive_r)))) begin
          rem_fwd_nxt     = 1'b0;
          rem_rev_nxt     = 1'b0;
          drive_start_nxt = '0;
        end
        act_fwd = fwd_stable_nxt || rem_fwd_nxt;
        act_rev = rev_stable_nxt || rem_rev_nxt;
        if (act_fwd && !act_rev) target = $signed({1'b0, fwd_tgt_mag});
        else if (act_rev && !act_fwd) target = -$signed({1'b0, rev_tgt_mag});
        else target = '0;

        // Ramp step, doubled when heading for standstill
        rate = (SPEED_W+1)'(accel_r) * (SPEED_W+1)'(RAMP_MULT);
        if (target == '0) rate = rate <<< 1;
        step_up = cur_w + rate;
        step_dn = cur_w - rate;
        if (cur_w < target) begin
          speed_nxt = (step_up > target) ? target[SPEED_W-1:0] : step_up[SPEED_W-1:0];
        end else if (cur_w > target) begin
          speed_nxt = (step_dn < target) ? target[SPEED_W-1:0] : step_dn[SPEED_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r        <= '0;
      fwd_seen_r    <= 1'b0;
      fwd_stable_r  <= 1'b0;
      fwd_chg_r     <= '0;
      rev_seen_r    <= 1'b0;
      rev_stable_r  <= 1'b0;
      rev_chg_r     <= '0;
      ready_flag_r  <= 1'b0;
      rel_valid_r   <= 1'b0;
      rel_start_r   <= '0;
      rem_fwd_r     <= 1'b0;
      rem_rev_r     <= 1'b0;
      last_cmd_r    <= '0;
      drive_start_r <= '0;
      speed_r       <= '0;
    end else if (work) begin
      tick_r        <= tick_nxt;
      fwd_seen_r    <= fwd_seen_nxt;
      fwd_stable_r  <= fwd_stable_nxt;
      fwd_chg_r     <= fwd_chg_nxt;
      rev_seen_r    <= rev_seen_nxt;
      rev_stable_r  <= rev_stable_nxt;
      rev_chg_r     <= rev_chg_nxt;
      ready_flag_r  <= ready_flag_nxt;
      rel_valid_r   <= rel_valid_nxt;
      rel_start_r   <= rel_start_nxt;
      rem_fwd_r     <= rem_fwd_nxt;
      rem_rev_r     <= rem_rev_nxt;
      last_cmd_r    <= last_cmd_nxt;
      drive_start_r <= drive_start_nxt;
      speed_r       <= speed_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  status_t out_status_r;
  speed_t  out_speed_r;
  logic    out_ready_flag_r, out_act_fwd_r, out_act_rev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (work) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      out_status_r     <= status_nxt;
      out_speed_r      <= ready_flag_nxt ? speed_nxt : '0;
      out_ready_flag_r <= ready_flag_nxt;
      out_act_fwd_r    <= fwd_stable_nxt || rem_fwd_nxt;
      out_act_rev_r    <= rev_stable_nxt || rem_rev_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = out_status_r;
  assign out_if.motor_speed    = out_speed_r;
  assign out_if.drive_ready    = out_ready_flag_r;
  assign out_if.active_forward = out_act_fwd_r;
  assign out_if.active_reverse = out_act_rev_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTH
  // Speed stays at zero while the interlock holds
  a_zero_while_locked: assert property (@(posedge clk) disable iff (!rst_n)
    !ready_flag_r |-> speed_r == '0)
    else $error("speed moved while interlock held");

  // Speed never leaves the full-scale range
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    (speed_r <= speed_t'(1000)) && (speed_r >= -speed_t'(1000)))
    else $error("speed out of range");

  // Once released, the interlock stays released
  a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(ready_flag_r))
    else $error("interlock re-engaged");

  // A processed tick advances the tick counter by one
  a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (work && s1_cmd_r == CMD_TICK) |=> tick_r == $past(tick_r) + tick_t'(1))
    else $error("tick counter did not advance");

  // A locked answer never comes with drive ready
  a_locked_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_LOCKED) |-> !out_ready_flag_r)
    else $error("locked result while drive ready");
`endif

endmodule
